// ===== src/fnv_hash_64_top_macros.svh =====
// ----------------------------------------------------------------------------
// fnv_hash_64_top_macros
// Assertion macros shared by the hash block; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FNV_HASH_64_TOP_MACROS_SVH
`define FNV_HASH_64_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on clk and disabled during rst
`define FNVH_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and disabled during rst
`define FNVH_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`else

`define FNVH_ASSERT_IMP(lbl, ant, cons, msg)
`define FNVH_ASSERT_NEXT(lbl, ant, cons, msg)

`endif

`endif

// ===== src/fnvh_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvh_pkg
// Constants, command types and hash step functions for the 64-bit FNV block.
// ----------------------------------------------------------------------------
package fnvh_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam logic [1:0] MODE_FNV1  = 2'd0;
  localparam logic [1:0] MODE_FNV1A = 2'd1;
  localparam logic [1:0] MODE_EXT   = 2'd2;

  localparam logic [2:0] ROUND_LAST = 3'd7;

  // where the result of the hash step goes
  typedef enum logic [1:0] {
    DST_RUN   = 2'd0,
    DST_OUT   = 2'd1,
    DST_FIRST = 2'd2,
    DST_SWAP  = 2'd3
  } dst_t;

  typedef struct packed {
    logic       step_en;
    logic       alt;        // xor before multiply
    logic       sel_first;  // byte from first_hash instead of the input
    logic [2:0] idx;        // big-endian byte index into first_hash
    dst_t       dst;
  } cmd_t;

  // multiply by the prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [63:0] mul_prime(input logic [63:0] h);
    mul_prime = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b,
                                           input logic alt);
    if (alt) begin
      fnv_step = mul_prime(h ^ {56'd0, b});
    end else begin
      fnv_step = mul_prime(h) ^ {56'd0, b};
    end
  endfunction

  function automatic logic [63:0] bswap(input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      bswap[i*8 +: 8] = v[(7-i)*8 +: 8];
    end
  endfunction

endpackage

// ===== src/fnvh_datapath.sv =====
// ----------------------------------------------------------------------------
// fnvh_datapath
// Hash registers, the shared FNV step unit and the result register.
// ----------------------------------------------------------------------------
module fnvh_datapath (
  input  logic          clk,
  input  logic          rst,
  input  fnvh_pkg::cmd_t cmd,
  input  logic [7:0]    data_byte,
  output logic [63:0]   digest
);
  import fnvh_pkg::*;

  logic [63:0] running_hash, running_next;
  logic [63:0] first_hash, first_next;
  logic [63:0] digest_q, digest_next;
  logic        digest_load;
  logic [7:0]  byte_sel;
  logic [63:0] step;

  // ~idx picks bytes from the most significant end
  assign byte_sel = cmd.sel_first ? first_hash[{~cmd.idx, 3'b000} +: 8] : data_byte;
  assign step     = fnv_step(running_hash, byte_sel, cmd.alt);

  always_comb begin
    running_next = running_hash;
    first_next   = first_hash;
    digest_next  = digest_q;
    digest_load  = 1'b0;
    if (cmd.step_en) begin
      case (cmd.dst)
        DST_RUN: begin
          running_next = step;
        end
        DST_OUT: begin
          digest_next  = step;
          digest_load  = 1'b1;
          running_next = FNV_BASIS;
        end
        DST_FIRST: begin
          first_next   = step;
          running_next = FNV_BASIS;
        end
        DST_SWAP: begin
          first_next   = first_hash ^ bswap(step);
          running_next = FNV_BASIS;
        end
        default: begin
          running_next = running_hash;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      first_hash   <= '0;
    end else begin
      running_hash <= running_next;
      first_hash   <= first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (digest_load) begin
      digest_q <= digest_next;
    end
  end

  assign digest = digest_q;

endmodule

// ===== src/fnvh_ctrl.sv =====
// ----------------------------------------------------------------------------
// fnvh_ctrl
// Mode register, handshakes and the sequencer of the extended finish.
// ----------------------------------------------------------------------------
module fnvh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [1:0]     cfg_wr_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           last_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output fnvh_pkg::cmd_t cmd
);
  import fnvh_pkg::*;

  `include "fnv_hash_64_top_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FIN1 = 3'b010,
    ST_FIN2 = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [2:0] round_count, round_count_next;
  logic [1:0] hash_mode;
  logic       out_valid_next;
  logic       out_free;
  logic       accept;
  logic       ext;
  logic       load_out;

  assign ext      = (hash_mode == MODE_EXT);
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next       = state;
    round_count_next = round_count;
    load_out         = 1'b0;
    cmd.step_en      = 1'b0;
    cmd.alt          = 1'b1;
    cmd.sel_first    = 1'b0;
    cmd.idx          = round_count;
    cmd.dst          = DST_RUN;
    case (state)
      ST_IDLE: begin
        cmd.step_en = accept;
        cmd.alt     = hash_mode[0];
        if (last_byte) begin
          cmd.dst = ext ? DST_FIRST : DST_OUT;
        end
        if (accept && last_byte) begin
          if (ext) begin
            state_next       = ST_FIN1;
            round_count_next = '0;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_FIN1: begin
        cmd.step_en      = 1'b1;
        cmd.sel_first    = 1'b1;
        round_count_next = round_count + 3'd1;
        if (round_count == ROUND_LAST) begin
          // last round of the first pass folds the swap into first_hash
          cmd.dst    = DST_SWAP;
          state_next = ST_FIN2;
        end
      end
      ST_FIN2: begin
        cmd.sel_first = 1'b1;
        if (round_count == ROUND_LAST) begin
          cmd.step_en = out_free;
          cmd.dst     = DST_OUT;
          if (out_free) begin
            load_out         = 1'b1;
            round_count_next = '0;
            state_next       = ST_IDLE;
          end
        end else begin
          cmd.step_en      = 1'b1;
          round_count_next = round_count + 3'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && out_stall) || load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_count <= '0;
      out_valid   <= 1'b0;
      hash_mode   <= MODE_FNV1A;
    end else begin
      state       <= state_next;
      round_count <= round_count_next;
      out_valid   <= out_valid_next;
      if (cfg_wr_en) begin
        hash_mode <= cfg_wr_data;
      end
    end
  end

  `FNVH_ASSERT_NEXT(a_plain_last_out, accept && last_byte && !ext, out_valid,
                    "plain last byte did not produce a result")
  `FNVH_ASSERT_NEXT(a_ext_start, accept && last_byte && ext,
                    state == ST_FIN1 && round_count == 3'd0,
                    "extended finish did not start at round zero")
  `FNVH_ASSERT_NEXT(a_pass_change, state == ST_FIN1 && round_count == ROUND_LAST,
                    state == ST_FIN2 && round_count == 3'd0,
                    "first pass did not hand over to second pass")
  `FNVH_ASSERT_NEXT(a_ext_done, state == ST_FIN2 && round_count == ROUND_LAST && out_free,
                    out_valid && state == ST_IDLE,
                    "extended digest not delivered at end of second pass")

endmodule

// ===== src/fnv_hash_64_top.sv =====
// ----------------------------------------------------------------------------
// fnv_hash_64_top
// 64-bit FNV message hash with FNV-1, FNV-1a and extended digest modes.
// ----------------------------------------------------------------------------
// Message bytes enter on the input channel (in_valid, in_stall, data_byte,
// last_byte); one transfer per byte, last_byte set on the final byte.
// The digest leaves on the output channel (out_valid, out_stall, digest),
// one transfer per message.
// The user must write hash_mode through cfg_wr_en / cfg_wr_data only while
// the block is idle; the block does not enforce it. Values: 0 FNV-1,
// 1 FNV-1a (also for 3), 2 extended digest. One byte is taken per cycle
// while the input is not stalled; the prime multiply is combinational,
// done as shifts and adds in the step unit. In FNV-1 and FNV-1a modes the
// digest is valid in the cycle after the last byte transfer. In extended
// mode the step unit runs two passes of eight rounds over the hashed word,
// then registers the digest, and the input is stalled during those rounds.
// The result register lets the next message stream in while a digest
// waits; a byte stalls only on a stalled waiting digest or extended rounds.
// Synchronous reset returns the running hash to the offset basis, clears
// out_valid and sets the mode to FNV-1a.
// ----------------------------------------------------------------------------
module fnv_hash_64_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest
);
  import fnvh_pkg::*;

  cmd_t cmd;

  fnvh_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd)
  );

  fnvh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .data_byte (data_byte),
    .digest    (digest)
  );

endmodule

// ===== verif/fnv_hash_64_top_test.sv =====
// ----------------------------------------------------------------------------
// fnv_hash_64_top_test
// Self-checking bench for the 64-bit FNV hash block. A queue-fed driver
// streams message bytes and a clocked monitor checks each digest against a
// bit-exact prediction. The run covers all four mode values, mode changes
// inside a message, mixes of sender and receiver idling, and long output
// hold-offs that back the block up into its input.
// ----------------------------------------------------------------------------
module fnv_hash_64_top_test;
  import fnvh_pkg::*;

  localparam logic [63:0] PRIME_64      = 64'h00000100000001b3;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;
  localparam int          SETTLE_CYCLES = 24;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PHASE_BYTES   = 37;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } hash_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest;

  hash_byte_t  pending_q[$];
  logic [63:0] digest_q[$];
  hash_byte_t  next_item;
  logic        byte_taken = 1'b0;

  logic [63:0] model_hash = FNV_BASIS;
  logic [1:0]  model_mode = MODE_FNV1A;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_phase = 1'b0;
  int hold_count = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int digests_seen = 0;
  int ext_digests = 0;

  fnv_hash_64_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .digest      (digest)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b,
                                           input logic xor_first);
    if (xor_first) begin
      return (h ^ {56'd0, b}) * PRIME_64;
    end
    return (h * PRIME_64) ^ {56'd0, b};
  endfunction

  // fnv-1a over the eight bytes of a word, most significant first
  function automatic logic [63:0] fnv1a_word(input logic [63:0] w);
    logic [63:0] h;
    h = FNV_BASIS;
    for (int k = 7; k >= 0; k--) begin
      h = fnv_fold(h, w[k*8 +: 8], 1'b1);
    end
    return h;
  endfunction

  function automatic logic [63:0] swap_word(input logic [63:0] w);
    logic [63:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k*8 +: 8] = w[(7-k)*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [63:0] extended_digest(input logic [63:0] h);
    logic [63:0] a;
    a = fnv1a_word(h);
    return fnv1a_word(h ^ swap_word(a));
  endfunction

  // ---------------- driver and receiver ----------------

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_q.pop_front();
        in_valid  <= 1'b1;
        data_byte <= next_item.value;
        last_byte <= next_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long hold-off counted here while hold_phase is up
  always @(negedge clk) begin
    if (hold_phase && hold_count < HOLD_CYCLES) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      if (!hold_phase) begin
        hold_count <= 0;
      end
    end
  end

  // ---------------- monitor, predictor, timeout ----------------

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
    byte_taken <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      digests_seen <= digests_seen + 1;
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest, expected none, actual %h", $time, digest);
        fail_count <= fail_count + 1;
      end else if (digest !== digest_q[0]) begin
        $display("%0t: digest mismatch, expected %h, actual %h", $time, digest_q[0], digest);
        fail_count <= fail_count + 1;
        void'(digest_q.pop_front());
      end else begin
        void'(digest_q.pop_front());
      end
    end
    if (!rst && in_valid && !in_stall) begin
      bytes_sent <= bytes_sent + 1;
      model_hash = fnv_fold(model_hash, data_byte, model_mode[0]);
      if (last_byte) begin
        if (model_mode == MODE_EXT) begin
          digest_q.push_back(extended_digest(model_hash));
          ext_digests <= ext_digests + 1;
        end else begin
          digest_q.push_back(model_hash);
        end
        model_hash = FNV_BASIS;
      end
    end
  end

  // ---------------- stimulus ----------------

  task automatic push_byte(input logic [7:0] value, input logic last);
    hash_byte_t it;
    it.value = value;
    it.last  = last;
    pending_q.push_back(it);
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end else if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // random bytes, the final one closing the message when close is set
  task automatic queue_bytes(input int len, input bit close);
    for (int k = 0; k < len; k++) begin
      push_byte(pick_byte(), close && (k == len - 1));
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $urandom_range(1, 4);
    end else if (r < 9) begin
      return $urandom_range(5, 16);
    end
    return $urandom_range(17, 64);
  endfunction

  // nothing queued, nothing on the wire, nothing outstanding, then settle
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_q.size() != 0 || in_valid || digest_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    model_mode = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_hold(input logic [1:0] m);
    int queued;
    write_mode(m);
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_phase     = 1'b1;
    queued = 0;
    while (queued < 60) begin
      int len;
      len = $urandom_range(1, 3);
      queue_bytes(len, 1'b1);
      queued += len;
    end
    wait_drained();
    hold_phase = 1'b0;
  endtask

  int idle_mix[4]  = '{0, 58, 0, 25};
  int stall_mix[4] = '{0, 0, 58, 25};
  logic [1:0] mode_list[4] = '{MODE_FNV1, MODE_EXT, MODE_FNV1A, MODE_SPARE};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset mode first, no write yet
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    push_byte(8'haa, 1'b0);
    push_byte(8'h55, 1'b1);
    write_mode(MODE_FNV1);
    @(posedge clk);
    push_byte(8'hff, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    write_mode(MODE_EXT);
    @(posedge clk);
    push_byte(8'h00, 1'b1);
    push_byte(8'hff, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hfe, 1'b1);
    // unused mode value behaves as fnv-1a
    write_mode(MODE_SPARE);
    @(posedge clk);
    push_byte(8'h61, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'hfe, 1'b1);
    // mode switched between bytes of one message
    write_mode(MODE_FNV1A);
    @(posedge clk);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    write_mode(MODE_FNV1);
    @(posedge clk);
    push_byte(8'h56, 1'b1);
    push_byte(8'h9c, 1'b0);
    write_mode(MODE_EXT);
    @(posedge clk);
    push_byte(8'hc3, 1'b1);

    run_hold(MODE_FNV1A);

    // random phases: every mode under every idle mix
    for (int p = 0; p < 16; p++) begin
      int queued;
      write_mode(mode_list[(p + p / 4) % 4]);
      @(posedge clk);
      send_idle_pct  = idle_mix[p / 4];
      recv_stall_pct = stall_mix[p / 4];
      queued = 0;
      while (queued < PHASE_BYTES) begin
        int len;
        len = pick_length();
        queue_bytes(len, 1'b1);
        queued += len;
      end
      // sometimes leave a message open across the next mode write
      if ($urandom_range(0, 1) == 1) begin
        queue_bytes($urandom_range(1, 3), 1'b0);
      end
    end

    run_hold(MODE_EXT);
    // close any open message so its digest is checked
    @(posedge clk);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    push_byte(pick_byte(), 1'b1);
    wait_drained();

    $display("covered %0d bytes and %0d digests, %0d of them extended", bytes_sent,
             digests_seen, ext_digests);
    $display("all four mode values, in-message mode changes, idle mixes and two hold-offs");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
